// File: src/utf8d_pkg.sv
// Shared types, constants and the lead-byte classifier for the UTF-8 decoder.
// Used by utf8_to_codepoint_decoder; depends on nothing else.
package utf8d_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CP_W    = 21;
   localparam int unsigned PEND_W  = 2;
   localparam int unsigned RSP_DW  = 24;  // code point padded to whole bytes

   localparam logic [1:0] CONT_TAG  = 2'b10;
   localparam logic [7:0] ONE_MAX   = 8'h7F;
   localparam logic [7:0] TWO_MIN   = 8'h80;
   localparam logic [7:0] TWO_MAX   = 8'hDF;
   localparam logic [7:0] THREE_MIN = 8'hE0;
   localparam logic [7:0] THREE_MAX = 8'hEF;
   localparam logic [7:0] FOUR_MIN  = 8'hF0;
   localparam logic [7:0] FOUR_MAX  = 8'hFF;

   localparam logic [7:0] MASK_TWO   = 8'h1F;
   localparam logic [7:0] MASK_THREE = 8'h0F;
   localparam logic [7:0] MASK_FOUR  = 8'h07;
   localparam logic [7:0] MASK_CONT  = 8'h3F;

   localparam logic [PEND_W-1:0] PEND_NONE  = 2'd0;
   localparam logic [PEND_W-1:0] PEND_ONE   = 2'd1;
   localparam logic [PEND_W-1:0] PEND_TWO   = 2'd2;
   localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

   typedef struct packed {
      logic [PEND_W-1:0] pend;
      logic [CP_W-1:0]   bits;
   } lead_type;

   // Classifies a byte as the start of a new sequence.
   function automatic lead_type classify_lead(input logic [BYTE_W-1:0] b);
      lead_type res;
      res.pend = PEND_NONE;
      res.bits = '0;
      unique case (b) inside
         [8'h00:ONE_MAX]: begin
            res.pend = PEND_NONE;
            res.bits = {{(CP_W-BYTE_W){1'b0}}, b};
         end
         [TWO_MIN:TWO_MAX]: begin
            res.pend = PEND_ONE;
            res.bits = {{(CP_W-BYTE_W){1'b0}}, b & MASK_TWO};
         end
         [THREE_MIN:THREE_MAX]: begin
            res.pend = PEND_TWO;
            res.bits = {{(CP_W-BYTE_W){1'b0}}, b & MASK_THREE};
         end
         [FOUR_MIN:FOUR_MAX]: begin
            res.pend = PEND_THREE;
            res.bits = {{(CP_W-BYTE_W){1'b0}}, b & MASK_FOUR};
         end
         default: begin
            res.pend = PEND_NONE;
            res.bits = '0;
         end
      endcase
      return res;
   endfunction

endpackage

// File: src/utf8_to_codepoint_decoder.sv
// Streaming UTF-8 to code point decoder, top level.
// Depends on utf8d_pkg for constants and the lead-byte classifier.
//
// Usage:
//   The req_ channel carries one text byte per beat in req_tdata, with
//   req_tlast marking the final byte of a string. The rsp_ channel returns
//   exactly one beat per input beat: rsp_tdata holds the code point (zero
//   when none completed), rsp_tuser is high when this byte completed a code
//   point, and rsp_tlast repeats the input's last flag.
//   Each beat passes an input register and a result register; the decode
//   itself (a six-bit shift, a mask and the lead classification) sits between
//   them. rsp_tvalid rises once the accepted beat has moved from the input
//   register into the result register, and one byte is accepted every cycle
//   while the receiver keeps up. When the receiver stalls, the result
//   register holds its beat; the input register still takes one more byte,
//   then req_tready drops until the result moves on.
//   A synchronous reset empties both registers and clears the pending
//   continuation count and the partial code point, so decoding restarts at a
//   fresh sequence. A sequence left open at the end of a string is dropped.
module utf8_to_codepoint_decoder
   import utf8d_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,   // [7:0] data_byte
   input  logic              req_tlast,   // last_byte
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_DW-1:0] rsp_tdata,   // [20:0] code_point, [23:21] zero
   output logic              rsp_tuser,   // [0] code_valid
   output logic              rsp_tlast    // end_of_text
);

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;

   logic              out_valid_ff, out_valid_in;
   logic [CP_W-1:0]   out_cp_ff;
   logic              out_cv_ff;
   logic              out_last_ff;

   logic [PEND_W-1:0] pend_ff, pend_in;
   logic [CP_W-1:0]   partial_ff, partial_in;

   logic              out_load;
   logic              in_load;
   logic              is_cont;
   lead_type          lead;
   logic [PEND_W-1:0] dec_pend;
   logic [CP_W-1:0]   dec_bits;
   logic              dec_valid;

   // The result register takes a beat whenever it is empty or being drained.
   assign out_load   = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || out_load;
   assign in_load    = req_tvalid && req_tready;

   assign in_valid_in  = in_load || (in_valid_ff && !out_load);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_tready);

   always_comb begin
      lead     = classify_lead(in_byte_ff);
      is_cont  = (pend_ff != PEND_NONE) && (in_byte_ff[7:6] == CONT_TAG);
      if (is_cont) begin
         dec_pend = pend_ff - PEND_ONE;
         dec_bits = {partial_ff[CP_W-7:0], in_byte_ff[5:0]};
      end else begin
         dec_pend = lead.pend;
         dec_bits = lead.bits;
      end
      dec_valid = (dec_pend == PEND_NONE);

      pend_in    = pend_ff;
      partial_in = partial_ff;
      if (out_load) begin
         if (dec_valid || in_last_ff) begin
            pend_in    = PEND_NONE;
            partial_in = '0;
         end else begin
            pend_in    = dec_pend;
            partial_in = dec_bits;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pend_ff      <= PEND_NONE;
         partial_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
         partial_ff   <= partial_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (out_load) begin
         out_cp_ff   <= dec_valid ? dec_bits : '0;
         out_cv_ff   <= dec_valid;
         out_last_ff <= in_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DW-CP_W){1'b0}}, out_cp_ff};
   assign rsp_tuser  = out_cv_ff;
   assign rsp_tlast  = out_last_ff;

   // Both registers come out of reset empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("registers not empty after reset");

   // A result without a completed code point carries a zero code point.
   a_zero_when_invalid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("code point nonzero without code_valid");

   // The end of a string always leaves the decoder with no open sequence.
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (out_load && in_last_ff) |=> (pend_ff == PEND_NONE && partial_ff == '0))
      else $error("open sequence survived end of string");

   // The partial code point never holds more bits than the open sequence allows.
   a_partial_width: assert property (@(posedge clock) disable iff (reset)
      ((pend_ff == PEND_NONE  && partial_ff == '0) ||
       (pend_ff == PEND_ONE   && partial_ff[CP_W-1:15] == '0) ||
       (pend_ff == PEND_TWO   && partial_ff[CP_W-1:9]  == '0) ||
       (pend_ff == PEND_THREE && partial_ff[CP_W-1:3]  == '0)))
      else $error("partial code point wider than its sequence state");

endmodule

// File: verif/testbench.sv
// Self-checking testbench for utf8_to_codepoint_decoder: random and directed byte
// strings, a byte-level decode predictor, and random stalls on both streams.
// Depends on utf8d_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module testbench;
   import utf8d_pkg::*;

   localparam int LONG_HOLD   = 300;
   localparam int STALL_LIMIT = 4000;
   localparam int TAIL_CYCLES = 10;
   localparam int PHASE_BYTES = 410;
   localparam int PRINT_CAP   = 40;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              end_flag;
   } text_beat_type;

   typedef struct packed {
      logic [CP_W-1:0] cp;
      logic            valid;
      logic            eot;
   } code_result_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [BYTE_W-1:0] req_tdata  = '0;
   logic              req_tlast  = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_DW-1:0] rsp_tdata;
   logic              rsp_tuser;
   logic              rsp_tlast;

   text_beat_type   byte_queue[$];
   code_result_type code_queue[$];
   text_beat_type   beat_on_bus;

   // Decoder state as the predictor sees it.
   logic [PEND_W-1:0] pend_cnt;
   logic [CP_W-1:0]   partial_cp;

   int tx_idle_pct = 22;
   int rx_idle_pct = 52;
   int holds_asked = 0;
   int holds_served = 0;
   int hold_left = 0;
   int error_count = 0;
   int stall_cycles = 0;
   int bytes_queued = 0;

   utf8_to_codepoint_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Advances the predicted decoder state by one byte and returns its result.
   function automatic code_result_type decode_byte(logic [BYTE_W-1:0] b, logic end_flag);
      code_result_type r;
      r.cp    = '0;
      r.valid = 1'b0;
      r.eot   = end_flag;
      if (pend_cnt != PEND_NONE && b[7:6] == CONT_TAG) begin
         partial_cp = {partial_cp[CP_W-7:0], b[5:0] & MASK_CONT[5:0]};
         pend_cnt   = pend_cnt - 1'b1;
      end else if (b <= ONE_MAX) begin
         pend_cnt   = PEND_NONE;
         partial_cp = CP_W'(b);
      end else if (b <= TWO_MAX) begin
         pend_cnt   = PEND_ONE;
         partial_cp = CP_W'(b & MASK_TWO);
      end else if (b <= THREE_MAX) begin
         pend_cnt   = PEND_TWO;
         partial_cp = CP_W'(b & MASK_THREE);
      end else begin
         pend_cnt   = PEND_THREE;
         partial_cp = CP_W'(b & MASK_FOUR);
      end
      if (pend_cnt == PEND_NONE) begin
         r.valid = 1'b1;
         r.cp    = partial_cp;
      end
      // A finished code point or the end of the string clears the state.
      if (r.valid || end_flag) begin
         pend_cnt   = PEND_NONE;
         partial_cp = '0;
      end
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [RSP_DW-1:0] want,
                                  logic [RSP_DW-1:0] got);
      if (error_count < PRINT_CAP)
         $display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t", field, want, got, $time);
      error_count++;
   endtask

   // Appends one beat at the tail of a beat queue.
   function automatic void append_beat(ref text_beat_type q[$], input text_beat_type b);
      q = {q, b};
   endfunction

   task automatic add_beat(logic [BYTE_W-1:0] data, logic end_flag);
      append_beat(byte_queue, '{data: data, end_flag: end_flag});
      bytes_queued++;
   endtask

   function automatic logic [BYTE_W-1:0] random_lead(int n);
      case (n)
         1:       return BYTE_W'($urandom_range(ONE_MAX, 0));
         2:       return BYTE_W'($urandom_range(TWO_MAX, TWO_MIN));
         3:       return BYTE_W'($urandom_range(THREE_MAX, THREE_MIN));
         default: return BYTE_W'($urandom_range(FOUR_MAX, FOUR_MIN));
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] random_cont();
      return {CONT_TAG, 6'($urandom_range(63, 0))};
   endfunction

   // One string: mostly well-formed sequences, some noise, truncated
   // sequences and stray continuation bytes. The final byte carries tlast.
   task automatic add_string();
      text_beat_type str[$];
      int nchars;
      int kind;
      int n;
      int k;
      nchars = $urandom_range(10, 1);
      for (int c = 0; c < nchars; c++) begin
         kind = $urandom_range(99, 0);
         n    = $urandom_range(4, 1);
         if (kind < 70) begin
            append_beat(str, '{data: random_lead(n), end_flag: 1'b0});
            for (int i = 1; i < n; i++)
               append_beat(str, '{data: random_cont(), end_flag: 1'b0});
         end else if (kind < 82) begin
            append_beat(str, '{data: BYTE_W'($urandom_range(255, 0)), end_flag: 1'b0});
         end else if (kind < 92) begin
            n = $urandom_range(4, 2);
            k = $urandom_range(n - 2, 0);
            append_beat(str, '{data: random_lead(n), end_flag: 1'b0});
            for (int i = 0; i < k; i++)
               append_beat(str, '{data: random_cont(), end_flag: 1'b0});
         end else begin
            append_beat(str, '{data: random_cont(), end_flag: 1'b0});
         end
      end
      str[str.size() - 1].end_flag = 1'b1;
      foreach (str[i]) add_beat(str[i].data, str[i].end_flag);
   endtask

   // Sender: holds a beat until it is taken, predicts it on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            code_queue = {code_queue, decode_byte(beat_on_bus.data, beat_on_bus.end_flag)};
         if (req_tvalid && !req_tready) begin
            // Beat still waiting; keep it on the bus.
         end else if (byte_queue.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
            beat_on_bus = byte_queue.pop_front();
            req_tdata  <= beat_on_bus.data;
            req_tlast  <= beat_on_bus.end_flag;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver backpressure, including the long hold-off that fills the decoder.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (holds_served != holds_asked) begin
         holds_served++;
         hold_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      code_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (code_queue.size() == 0) begin
            report_mismatch("unexpected beat", '0, rsp_tdata);
         end else begin
            want = code_queue.pop_front();
            if (rsp_tdata !== RSP_DW'(want.cp))
               report_mismatch("code_point", RSP_DW'(want.cp), rsp_tdata);
            if (rsp_tuser !== want.valid)
               report_mismatch("code_valid", RSP_DW'(want.valid), RSP_DW'(rsp_tuser));
            if (rsp_tlast !== want.eot)
               report_mismatch("end_of_text", RSP_DW'(want.eot), RSP_DW'(rsp_tlast));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      pend_cnt   = PEND_NONE;
      partial_cp = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed strings: range edges, every lead class, the largest code
      // point, stray continuations, a broken sequence and an unfinished one.
      add_beat(8'h00, 1'b0);
      add_beat(8'h7F, 1'b0);
      add_beat(8'h80, 1'b0);
      add_beat(8'hBF, 1'b0);
      add_beat(8'hC3, 1'b0); add_beat(8'hA9, 1'b0);
      add_beat(8'hDF, 1'b0); add_beat(8'hBF, 1'b0);
      add_beat(8'hE2, 1'b0); add_beat(8'h82, 1'b0); add_beat(8'hAC, 1'b0);
      add_beat(8'hEF, 1'b0); add_beat(8'hBF, 1'b0); add_beat(8'hBF, 1'b0);
      add_beat(8'hF0, 1'b0); add_beat(8'h9F, 1'b0); add_beat(8'h98, 1'b0);
      add_beat(8'h80, 1'b0);
      add_beat(8'hFF, 1'b0); add_beat(8'hBF, 1'b0); add_beat(8'hBF, 1'b0);
      add_beat(8'hBF, 1'b0);
      add_beat(8'hE2, 1'b0); add_beat(8'h41, 1'b0);
      add_beat(8'hF0, 1'b0); add_beat(8'h90, 1'b1);
      add_beat(8'hC3, 1'b0); add_beat(8'hA9, 1'b1);

      while (bytes_queued < PHASE_BYTES) add_string();
      while (byte_queue.size() != 0) @(negedge clock);

      tx_idle_pct = 52;
      rx_idle_pct = 22;
      while (bytes_queued < 2 * PHASE_BYTES) add_string();
      while (byte_queue.size() != 0) @(negedge clock);

      // No idling; the receiver stops for a long stretch while the sender
      // keeps offering, so the decoder fills and drops req_tready.
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      while (bytes_queued < 3 * PHASE_BYTES) add_string();
      holds_asked++;

      while (byte_queue.size() != 0 || req_tvalid || code_queue.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
src/utf8d_pkg.sv
src/utf8_to_codepoint_decoder.sv
verif/testbench.sv
